### sv/mnmm_pkg.sv
package mnmm_pkg;

  // Status byte kinds, before the channel is ORed in.
  localparam logic [7:0] STATUS_CC       = 8'hB0;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

  // Register indexes, taken from byte address bits [4:2].
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_MIDI_CHANNEL   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMBRE_CTRL    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHARACTER_CTRL = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NORMAL_VEL     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ACCENT_VEL     = 3'd4;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [3:0] RST_MIDI_CHANNEL   = 4'd0;
  localparam logic [6:0] RST_TIMBRE_CTRL    = 7'd71;
  localparam logic [6:0] RST_CHARACTER_CTRL = 7'd74;
  localparam logic [6:0] RST_NORMAL_VEL     = 7'd80;
  localparam logic [6:0] RST_ACCENT_VEL     = 7'd112;

  // One classified step: which messages to send and the data they need.
  typedef struct packed {
    logic       send_timbre;
    logic       send_character;
    logic       send_off;
    logic       send_on;
    logic [6:0] timbre;
    logic [6:0] character;
    logic [6:0] off_note;
    logic [6:0] on_note;
    logic       accent;
  } cmd_t;

  typedef struct packed {
    logic [3:0] midi_channel;
    logic [6:0] timbre_controller;
    logic [6:0] character_controller;
    logic [6:0] normal_velocity;
    logic [6:0] accent_velocity;
  } cfg_t;

endpackage

### sv/mnmm_front.sv
module mnmm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [7:0]         timbre_value_i,
  input  logic [7:0]         character_value_i,
  input  logic               start_note_i,
  input  logic               gate_open_i,
  input  logic [6:0]         note_number_i,
  input  logic               accented_i,
  input  logic               q_ready_i,
  output logic               q_push_o,
  output mnmm_pkg::cmd_t     q_cmd_o
);

  logic       has_started_q, has_started_d;
  logic [6:0] last_timbre_q, last_timbre_d;
  logic [6:0] last_character_q, last_character_d;
  logic [6:0] sounding_note_q, sounding_note_d;
  logic       note_held_q, note_held_d;
  logic       accept;
  logic [6:0] t_half;
  logic [6:0] c_half;
  mnmm_pkg::cmd_t cmd;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign t_half     = timbre_value_i[7:1];
  assign c_half     = character_value_i[7:1];

  always_comb begin
    cmd              = '0;
    cmd.timbre       = t_half;
    cmd.character    = c_half;
    cmd.off_note     = sounding_note_q;
    cmd.on_note      = note_number_i;
    cmd.accent       = accented_i;
    has_started_d    = has_started_q;
    last_timbre_d    = last_timbre_q;
    last_character_d = last_character_q;
    sounding_note_d  = sounding_note_q;
    note_held_d      = note_held_q;
    if (func_i) begin
      if (note_held_q) begin
        cmd.send_off = 1'b1;
        note_held_d  = 1'b0;
      end
    end else begin
      cmd.send_timbre    = !has_started_q || (t_half != last_timbre_q);
      cmd.send_character = !has_started_q || (c_half != last_character_q);
      last_timbre_d      = t_half;
      last_character_d   = c_half;
      has_started_d      = 1'b1;
      if (start_note_i) begin
        cmd.send_off    = note_held_q;
        cmd.send_on     = 1'b1;
        sounding_note_d = note_number_i;
        note_held_d     = 1'b1;
      end else if (!gate_open_i && note_held_q) begin
        cmd.send_off = 1'b1;
        note_held_d  = 1'b0;
      end
    end
  end

  assign q_cmd_o  = cmd;
  assign q_push_o = accept &
                    (cmd.send_timbre | cmd.send_character | cmd.send_off | cmd.send_on);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_started_q    <= 1'b0;
      last_timbre_q    <= '0;
      last_character_q <= '0;
      sounding_note_q  <= '0;
      note_held_q      <= 1'b0;
    end else if (accept) begin
      has_started_q    <= has_started_d;
      last_timbre_q    <= last_timbre_d;
      last_character_q <= last_character_d;
      sounding_note_q  <= sounding_note_d;
      note_held_q      <= note_held_d;
    end
  end

endmodule

### sv/mnmm_queue.sv
module mnmm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mnmm_pkg::cmd_t  push_cmd_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mnmm_pkg::cmd_t  head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mnmm_pkg::cmd_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign ready_o = (count_q != CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

### sv/mnmm_back.sv
module mnmm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mnmm_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  mnmm_pkg::cmd_t  q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      status_byte_o,
  output logic [6:0]      first_data_o,
  output logic [6:0]      second_data_o,
  output logic            last_message_o
);

  mnmm_pkg::cmd_t cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic       out_valid_q;
  logic [7:0] status_q, status_d;
  logic [6:0] first_q, first_d;
  logic [6:0] second_q, second_d;
  logic       last_q, last_d;
  logic       slot_free, advance, done;
  logic [3:0] rest;

  assign slot_free = !out_valid_q || out_ready_i;
  assign advance   = cur_valid_q && slot_free;

  // Priority: timbre CC, character CC, note off, note on.
  always_comb begin
    cur_d    = cur_q;
    status_d = mnmm_pkg::STATUS_CC;
    first_d  = cfg_i.timbre_controller;
    second_d = cur_q.timbre;
    if (cur_q.send_timbre) begin
      cur_d.send_timbre = 1'b0;
    end else if (cur_q.send_character) begin
      first_d  = cfg_i.character_controller;
      second_d = cur_q.character;
      cur_d.send_character = 1'b0;
    end else if (cur_q.send_off) begin
      status_d = mnmm_pkg::STATUS_NOTE_OFF;
      first_d  = cur_q.off_note;
      second_d = '0;
      cur_d.send_off = 1'b0;
    end else begin
      status_d = mnmm_pkg::STATUS_NOTE_ON;
      first_d  = cur_q.on_note;
      second_d = cur_q.accent ? cfg_i.accent_velocity : cfg_i.normal_velocity;
      cur_d.send_on = 1'b0;
    end
    status_d = status_d | {4'h0, cfg_i.midi_channel};
    rest     = {cur_d.send_timbre, cur_d.send_character, cur_d.send_off, cur_d.send_on};
    done     = (rest == '0);
    last_d   = done;
  end

  // Take the next command when idle or as the current one sends its last message.
  assign q_pop_o = q_valid_i && (!cur_valid_q || (advance && done));

  always_comb begin
    cur_valid_d = cur_valid_q;
    if (advance && done) begin
      cur_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      cur_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_head_i;
    end else if (advance) begin
      cur_q <= cur_d;
    end
    if (advance) begin
      status_q <= status_d;
      first_q  <= first_d;
      second_q <= second_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_byte_o  = status_q;
  assign first_data_o   = first_q;
  assign second_data_o  = second_q;
  assign last_message_o = last_q;

endmodule

### sv/mono_note_event_to_midi_messages.sv
// Channel   Direction  Handshake                         Payload
// in        input      in_valid_i / in_ready_o           func, modulation values, note, flags
// out       output     out_valid_o / out_ready_i         status byte, two data bytes, last flag
// cfg       input      psel/penable/pwrite, pready=1     five registers at byte address 4*i
//
// Each transaction on the input produces zero to four MIDI messages, and the back end
// emits one message per cycle from its output register unless the output stalls,
// so an input item with messages takes one to four output transfers; an item with no
// messages is taken at the front and sends nothing to the back. The first message of
// an item passes the queue, the current-command register and the output register.
// The front runs ahead by the queue depth plus the command the back end is working on.
// Reset clears the note and controller tracking state and loads the register defaults.
// A stall on the output holds the current message and, once the queue fills, the input.
module mono_note_event_to_midi_messages #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Step events.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  timbre_value_i,
  input  logic [7:0]  character_value_i,
  input  logic        start_note_i,
  input  logic        gate_open_i,
  input  logic [6:0]  note_number_i,
  input  logic        accented_i,
  // MIDI messages.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  status_byte_o,
  output logic [6:0]  first_data_o,
  output logic [6:0]  second_data_o,
  output logic        last_message_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mnmm_pkg::PADDR_W-1:0] paddr,
  input  logic [mnmm_pkg::PDATA_W-1:0] pwdata,
  output logic [mnmm_pkg::PDATA_W-1:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  mnmm_pkg::cfg_t cfg_q;
  logic           cfg_write;
  logic [mnmm_pkg::REG_IDX_W-1:0] reg_idx;

  mnmm_pkg::cmd_t push_cmd, head_cmd;
  logic           q_push, q_ready, q_pop, q_valid;
  logic [CW-1:0]  q_count;

  // Configuration registers. The user must write these only while the block is idle; the
  // block itself does not enforce it. The back end reads them directly while building messages.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[mnmm_pkg::REG_IDX_W+1:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.midi_channel         <= mnmm_pkg::RST_MIDI_CHANNEL;
      cfg_q.timbre_controller    <= mnmm_pkg::RST_TIMBRE_CTRL;
      cfg_q.character_controller <= mnmm_pkg::RST_CHARACTER_CTRL;
      cfg_q.normal_velocity      <= mnmm_pkg::RST_NORMAL_VEL;
      cfg_q.accent_velocity      <= mnmm_pkg::RST_ACCENT_VEL;
    end else if (cfg_write) begin
      case (reg_idx)
        mnmm_pkg::REG_MIDI_CHANNEL:   cfg_q.midi_channel         <= pwdata[3:0];
        mnmm_pkg::REG_TIMBRE_CTRL:    cfg_q.timbre_controller    <= pwdata[6:0];
        mnmm_pkg::REG_CHARACTER_CTRL: cfg_q.character_controller <= pwdata[6:0];
        mnmm_pkg::REG_NORMAL_VEL:     cfg_q.normal_velocity      <= pwdata[6:0];
        mnmm_pkg::REG_ACCENT_VEL:     cfg_q.accent_velocity      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mnmm_pkg::REG_MIDI_CHANNEL:   prdata = {28'h0, cfg_q.midi_channel};
      mnmm_pkg::REG_TIMBRE_CTRL:    prdata = {25'h0, cfg_q.timbre_controller};
      mnmm_pkg::REG_CHARACTER_CTRL: prdata = {25'h0, cfg_q.character_controller};
      mnmm_pkg::REG_NORMAL_VEL:     prdata = {25'h0, cfg_q.normal_velocity};
      mnmm_pkg::REG_ACCENT_VEL:     prdata = {25'h0, cfg_q.accent_velocity};
      default:                      prdata = '0;
    endcase
  end

  // Front end: tracks held note and last controller values, and decides which
  // messages each step needs.
  mnmm_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .timbre_value_i    (timbre_value_i),
    .character_value_i (character_value_i),
    .start_note_i      (start_note_i),
    .gate_open_i       (gate_open_i),
    .note_number_i     (note_number_i),
    .accented_i        (accented_i),
    .q_ready_i         (q_ready),
    .q_push_o          (q_push),
    .q_cmd_o           (push_cmd)
  );

  // Command queue between the two halves.
  mnmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd),
    .count_o    (q_count)
  );

  // Back end: serializes each command into messages, one per cycle unless the output stalls.
  mnmm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_head_i       (head_cmd),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_byte_o  (status_byte_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o),
    .last_message_o (last_message_o)
  );

  // The queue never holds more commands than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  // Every message carries one of the three message kinds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_byte_o[7:4] == mnmm_pkg::STATUS_CC[7:4] ||
                     status_byte_o[7:4] == mnmm_pkg::STATUS_NOTE_ON[7:4] ||
                     status_byte_o[7:4] == mnmm_pkg::STATUS_NOTE_OFF[7:4]))
    else $error("bad message kind");

  // The channel nibble always matches the channel register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_byte_o[3:0] == cfg_q.midi_channel))
    else $error("channel nibble mismatch");

  // Note-off messages always carry zero velocity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_byte_o[7:4] == mnmm_pkg::STATUS_NOTE_OFF[7:4])
      |-> (second_data_o == '0))
    else $error("note off with nonzero velocity");

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A step transaction either advances the sequencer or flushes the held note.
  typedef enum logic {
    EV_STEP  = 1'b0,
    EV_FLUSH = 1'b1
  } event_kind_e;

  typedef struct packed {
    event_kind_e func;
    logic [7:0]  timbre_value;
    logic [7:0]  character_value;
    logic        start_note;
    logic        gate_open;
    logic [6:0]  note_number;
    logic        accented;
  } step_event_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic       last_message;
  } midi_msg_t;

  // The long receiver hold-off has to outlast the command queue and the output register
  // by a wide margin so that the input side is seen stalling for many cycles.
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  // A flush with no held note produces nothing, so after the last message the front end
  // may still be busy. This many cycles cover it comfortably.
  localparam int unsigned SETTLE_CYCLES   = 10;
  localparam int unsigned MAX_PRINTED     = 40;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  step_event_t         drv_event   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          status_byte_o;
  logic [6:0]          first_data_o;
  logic [6:0]          second_data_o;
  logic                last_message_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [mnmm_pkg::PADDR_W-1:0]  paddr  = '0;
  logic [mnmm_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [mnmm_pkg::PDATA_W-1:0]  prdata;
  logic                pready;

  // Testbench copy of the configuration registers, updated as each write completes.
  logic [3:0] cfg_channel     = mnmm_pkg::RST_MIDI_CHANNEL;
  logic [6:0] cfg_timbre_ctrl = mnmm_pkg::RST_TIMBRE_CTRL;
  logic [6:0] cfg_char_ctrl   = mnmm_pkg::RST_CHARACTER_CTRL;
  logic [6:0] cfg_normal_vel  = mnmm_pkg::RST_NORMAL_VEL;
  logic [6:0] cfg_accent_vel  = mnmm_pkg::RST_ACCENT_VEL;

  // Tracking state of the voice as the predictor sees it.
  logic       seen_step      = 1'b0;
  logic [6:0] prev_timbre    = '0;
  logic [6:0] prev_character = '0;
  logic [6:0] sounding_note  = '0;
  logic       note_held      = 1'b0;

  step_event_t pending_events[$];
  midi_msg_t   expected_msgs[$];

  // Stimulus knobs read by the driver and receiver, and the counters that those two keep.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned send_calm      = 0;
  int unsigned recv_calm      = 0;

  // Set at each rising edge when the input transaction completed; the driver reads it at
  // the following falling edge to decide whether to present the next item.
  logic in_took = 1'b0;

  int unsigned errors         = 0;
  int unsigned steps_taken    = 0;
  int unsigned msgs_checked   = 0;
  int unsigned input_stalls   = 0;
  int unsigned settings_used  = 0;

  // Stimulus-side memory of the last modulation values, so random steps can repeat them.
  logic [7:0] gen_timbre    = '0;
  logic [7:0] gen_character = '0;

  mono_note_event_to_midi_messages u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (drv_event.func),
    .timbre_value_i   (drv_event.timbre_value),
    .character_value_i(drv_event.character_value),
    .start_note_i     (drv_event.start_note),
    .gate_open_i      (drv_event.gate_open),
    .note_number_i    (drv_event.note_number),
    .accented_i       (drv_event.accented),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_byte_o    (status_byte_o),
    .first_data_o     (first_data_o),
    .second_data_o    (second_data_o),
    .last_message_o   (last_message_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops messages.
  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s of message %0d: got %0h, want %0h",
                                what, msgs_checked, got, want));
    end
  endtask

  // Appends one message to the expectations, with the channel ORed into the status byte.
  function automatic void emit_msg(input logic [7:0] kind, input logic [6:0] d1,
                                   input logic [6:0] d2);
    midi_msg_t m;
    m.status_byte  = kind | {4'h0, cfg_channel};
    m.first_data   = d1;
    m.second_data  = d2;
    m.last_message = 1'b0;
    expected_msgs.push_back(m);
  endfunction

  function automatic void release_sounding_note();
    emit_msg(mnmm_pkg::STATUS_NOTE_OFF, sounding_note, 7'd0);
    note_held = 1'b0;
  endfunction

  // Works out the messages that one accepted transaction causes and advances the voice
  // state. The last message of the group carries the last flag.
  function automatic void translate_event(input step_event_t ev);
    int unsigned base;
    logic [6:0]  t;
    logic [6:0]  c;
    midi_msg_t   tail;
    base = expected_msgs.size();
    t    = ev.timbre_value[7:1];
    c    = ev.character_value[7:1];
    if (ev.func == EV_FLUSH) begin
      // Flush touches only the held note; the step fields are ignored.
      if (note_held) begin
        release_sounding_note();
      end
    end else begin
      if (!seen_step || t != prev_timbre) begin
        emit_msg(mnmm_pkg::STATUS_CC, cfg_timbre_ctrl, t);
        prev_timbre = t;
      end
      if (!seen_step || c != prev_character) begin
        emit_msg(mnmm_pkg::STATUS_CC, cfg_char_ctrl, c);
        prev_character = c;
      end
      seen_step = 1'b1;
      if (ev.start_note) begin
        // A start wins over the gate: the new note sounds even with the gate low.
        if (note_held) begin
          release_sounding_note();
        end
        emit_msg(mnmm_pkg::STATUS_NOTE_ON, ev.note_number,
                 ev.accented ? cfg_accent_vel : cfg_normal_vel);
        sounding_note = ev.note_number;
        note_held     = 1'b1;
      end else if (!ev.gate_open && note_held) begin
        release_sounding_note();
      end
    end
    if (expected_msgs.size() > base) begin
      tail = expected_msgs.pop_back();
      tail.last_message = 1'b1;
      expected_msgs.push_back(tail);
    end
  endfunction

  task automatic check_message();
    midi_msg_t want;
    if (expected_msgs.size() == 0) begin
      report_mismatch($sformatf("message %0h %0h %0h last=%b arrived with none expected",
                                status_byte_o, first_data_o, second_data_o,
                                last_message_o));
    end else begin
      want = expected_msgs.pop_front();
      msgs_checked++;
      compare_field("status byte", status_byte_o, want.status_byte);
      compare_field("first data", 8'(first_data_o), 8'(want.first_data));
      compare_field("second data", 8'(second_data_o), 8'(want.second_data));
      compare_field("last flag", 8'(last_message_o), 8'(want.last_message));
    end
  endtask

  // Input driver. A new item goes out only after the previous one was taken, so valid
  // and payload hold steady while the block stalls. Random idle cycles are interleaved,
  // with occasional calm stretches that send back to back.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (send_calm > 0) begin
        send_calm--;
      end else if ($urandom_range(99) < 2) begin
        send_calm = $urandom_range(30, 10);
      end
      if (pending_events.size() != 0 &&
          (send_calm > 0 || $urandom_range(99) >= send_idle_pct)) begin
        drv_event  <= pending_events.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output receiver. A long hold-off is served whenever the stimulus asks for one;
  // otherwise ready stalls at random, again with calm stretches.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (recv_calm > 0) begin
      recv_calm--;
      out_ready_i <= 1'b1;
    end else begin
      if ($urandom_range(99) < 2) begin
        recv_calm = $urandom_range(30, 10);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor. The input transaction is predicted before the output is checked, so a
  // message can never be compared ahead of the step that caused it.
  always @(posedge clk_i) begin
    in_took = rst_ni && ((in_valid_i & in_ready_o) === 1'b1);
    if (in_took) begin
      translate_event(drv_event);
      steps_taken++;
    end
    if (rst_ni && in_valid_i && in_ready_o === 1'b0) begin
      input_stalls++;
    end
    if (rst_ni && (out_valid_o & out_ready_i) === 1'b1) begin
      check_message();
    end
  end

  // One APB transfer: setup cycle, then access cycle until pready is seen high.
  task automatic apb_access(input logic [mnmm_pkg::REG_IDX_W-1:0] idx, input logic wr,
                            input logic [mnmm_pkg::PDATA_W-1:0] wdata,
                            output logic [mnmm_pkg::PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= mnmm_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register with random junk above its width, reads it back, and updates the
  // testbench copy.
  task automatic write_reg(input logic [mnmm_pkg::REG_IDX_W-1:0] idx,
                           input logic [6:0] value);
    logic [mnmm_pkg::PDATA_W-1:0] mask;
    logic [mnmm_pkg::PDATA_W-1:0] rdata;
    mask = (idx == mnmm_pkg::REG_MIDI_CHANNEL) ? 32'h0000_000F : 32'h0000_007F;
    apb_access(idx, 1'b1, ($urandom & ~mask) | ({25'd0, value} & mask), rdata);
    apb_access(idx, 1'b0, '0, rdata);
    if ((rdata & mask) !== ({25'd0, value} & mask)) begin
      report_mismatch($sformatf("register %0d read back %0h, want %0h",
                                idx, rdata & mask, {25'd0, value} & mask));
    end
    case (idx)
      mnmm_pkg::REG_MIDI_CHANNEL:   cfg_channel     = value[3:0];
      mnmm_pkg::REG_TIMBRE_CTRL:    cfg_timbre_ctrl = value;
      mnmm_pkg::REG_CHARACTER_CTRL: cfg_char_ctrl   = value;
      mnmm_pkg::REG_NORMAL_VEL:     cfg_normal_vel  = value;
      mnmm_pkg::REG_ACCENT_VEL:     cfg_accent_vel  = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [3:0] channel, input logic [6:0] timbre_ctrl,
                                input logic [6:0] char_ctrl, input logic [6:0] normal_vel,
                                input logic [6:0] accent_vel);
    write_reg(mnmm_pkg::REG_MIDI_CHANNEL, {3'd0, channel});
    write_reg(mnmm_pkg::REG_TIMBRE_CTRL, timbre_ctrl);
    write_reg(mnmm_pkg::REG_CHARACTER_CTRL, char_ctrl);
    write_reg(mnmm_pkg::REG_NORMAL_VEL, normal_vel);
    write_reg(mnmm_pkg::REG_ACCENT_VEL, accent_vel);
    settings_used++;
  endtask

  // Blocks until every queued item is taken and every predicted message has arrived,
  // then lets the block settle before anything else happens.
  task automatic wait_for_drain();
    while (pending_events.size() != 0 || in_valid_i || expected_msgs.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic step_event_t make_step(input logic [7:0] t, input logic [7:0] c,
                                            input logic start, input logic gate,
                                            input logic [6:0] note, input logic acc);
    step_event_t ev;
    ev.func            = EV_STEP;
    ev.timbre_value    = t;
    ev.character_value = c;
    ev.start_note      = start;
    ev.gate_open       = gate;
    ev.note_number     = note;
    ev.accented        = acc;
    return ev;
  endfunction

  // Mostly well-formed steps: modulation values that usually repeat (sometimes differing
  // only in the bit that halving drops), notes starting and releasing, plus some flushes
  // carrying junk in the step fields.
  function automatic step_event_t random_step();
    step_event_t ev;
    ev = make_step(8'($urandom), 8'($urandom), ($urandom_range(99) < 40),
                   1'($urandom), 7'($urandom), 1'($urandom));
    if ($urandom_range(99) < 12) begin
      ev.func = EV_FLUSH;
    end else begin
      case ($urandom_range(3))
        0, 1: ev.timbre_value = gen_timbre;
        2:    ev.timbre_value = gen_timbre ^ 8'h01;
        default: ;
      endcase
      case ($urandom_range(3))
        0, 1: ev.character_value = gen_character;
        2:    ev.character_value = gen_character ^ 8'h01;
        default: ;
      endcase
      gen_timbre    = ev.timbre_value;
      gen_character = ev.character_value;
    end
    return ev;
  endfunction

  task automatic queue_random(input int unsigned count);
    repeat (count) pending_events.push_back(random_step());
  endtask

  initial begin
    step_event_t ev;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the reset register values and no idling.
    // A flush right after reset has nothing to release.
    ev = make_step(8'h00, 8'h00, 1'b0, 1'b0, 7'h00, 1'b0);
    ev.func = EV_FLUSH;
    pending_events.push_back(ev);
    // The first step sends both controllers even at value zero; the gate is low with
    // nothing held, so no note-off follows.
    pending_events.push_back(make_step(8'h00, 8'h00, 1'b0, 1'b0, 7'h00, 1'b0));
    // Odd inputs halve to the same values: no controllers. Start with the gate low
    // still holds the note.
    pending_events.push_back(make_step(8'h01, 8'h01, 1'b1, 1'b0, 7'h00, 1'b0));
    // Top values with an accented retrigger: two controllers, note-off, note-on.
    pending_events.push_back(make_step(8'hFF, 8'hFF, 1'b1, 1'b1, 7'h7F, 1'b1));
    pending_events.push_back(make_step(8'hFF, 8'hFF, 1'b0, 1'b1, 7'h7F, 1'b0));
    pending_events.push_back(make_step(8'hFE, 8'hFE, 1'b0, 1'b0, 7'h00, 1'b1));
    pending_events.push_back(make_step(8'hFE, 8'hFE, 1'b0, 1'b0, 7'h7F, 1'b0));
    pending_events.push_back(make_step(8'hAA, 8'h55, 1'b1, 1'b0, 7'h2A, 1'b0));
    // Flush with every step field set: only the held note is released, and the stored
    // controller values stay as they were.
    ev = make_step(8'h00, 8'h00, 1'b1, 1'b1, 7'h55, 1'b1);
    ev.func = EV_FLUSH;
    pending_events.push_back(ev);
    pending_events.push_back(ev);
    pending_events.push_back(make_step(8'hAA, 8'h80, 1'b1, 1'b1, 7'h55, 1'b1));
    pending_events.push_back(make_step(8'h02, 8'h80, 1'b0, 1'b1, 7'h2A, 1'b0));
    // Retrigger of the same note.
    pending_events.push_back(make_step(8'h02, 8'h81, 1'b1, 1'b1, 7'h55, 1'b0));
    pending_events.push_back(make_step(8'h55, 8'hAA, 1'b0, 1'b1, 7'h2A, 1'b1));
    ev.func = EV_FLUSH;
    pending_events.push_back(ev);
    pending_events.push_back(make_step(8'h7F, 8'hFE, 1'b0, 1'b0, 7'h7F, 1'b1));
    gen_timbre    = 8'h7F;
    gen_character = 8'hFE;
    wait_for_drain();

    // Every register at its top value, no idling.
    apply_settings(4'hF, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
    queue_random(60);
    wait_for_drain();

    // Every register at zero, sender idle most of the time.
    apply_settings(4'h0, 7'h00, 7'h00, 7'h00, 7'h00);
    send_idle_pct = 57;
    queue_random(60);
    wait_for_drain();

    // Random settings, receiver stalling, and one long hold-off while the sender keeps
    // offering items so that the command queue fills and the input stalls.
    apply_settings(4'($urandom), 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    queue_random(60);
    hold_requests++;
    wait_for_drain();

    // Random settings, both sides idling, with a full pause in the middle until every
    // predicted message has come out.
    apply_settings(4'($urandom), 7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    send_idle_pct  = 35;
    recv_stall_pct = 35;
    queue_random(30);
    wait_for_drain();
    queue_random(30);
    wait_for_drain();
    repeat (20) @(posedge clk_i);

    $display("Ran %0d step and flush transactions producing %0d checked MIDI messages",
             steps_taken, msgs_checked);
    $display("over %0d register settings; the input was back-pressured for %0d cycles.",
             settings_used, input_stalls);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
